// ----- src/uradix_pkg.sv -----
// ----------------------------------------------------------------------------
// uradix_pkg
// Shared constants, types and functions of the unsigned to radix ASCII
// converter.
// ----------------------------------------------------------------------------
package uradix_pkg;

  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned NUMBER_W    = 64;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned CHAR_W      = 7;

  localparam int unsigned DIGIT_SLOTS = 64;
  localparam int unsigned SLOT_W      = $clog2(DIGIT_SLOTS);
  localparam int unsigned COUNT_W     = $clog2(DIGIT_SLOTS + 1);

  localparam int unsigned BITS_PER_CYCLE = 8;
  localparam int unsigned DIV_STEPS      = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int unsigned SHIFT_W        = DIV_STEPS * BITS_PER_CYCLE;
  localparam int unsigned STEP_W         = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA    = CHAR_W'(65);
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = DIGIT_W'(10);

  typedef struct packed {
    logic [SHIFT_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } item_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_LIMIT) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_ALPHA + CHAR_W'(d) - CHAR_W'(DECIMAL_LIMIT);
    end
    return c;
  endfunction

endpackage

// ----- src/uradix_front.sv -----
// ----------------------------------------------------------------------------
// uradix_front
// Accepts input transactions, clamps the radix, masks the value and holds
// the items in a short queue until the conversion engine takes them.
// ----------------------------------------------------------------------------
module uradix_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [uradix_pkg::NUMBER_W-1:0]     number_i,
  input  logic [uradix_pkg::RADIX_W-1:0]      radix_i,
  output logic                                item_valid_o,
  input  logic                                item_take_i,
  output uradix_pkg::item_t                   item_o
);

  uradix_pkg::item_t                  queue_q [uradix_pkg::QUEUE_DEPTH];
  uradix_pkg::item_t                  new_item;
  logic [uradix_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [uradix_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [uradix_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                               push;
  logic                               pop;

  always_comb begin
    new_item.value = uradix_pkg::SHIFT_W'(number_i[uradix_pkg::VALUE_WIDTH-1:0]);
    if (radix_i < uradix_pkg::RADIX_MIN) begin
      new_item.radix = uradix_pkg::RADIX_MIN;
    end else if (radix_i > uradix_pkg::RADIX_MAX) begin
      new_item.radix = uradix_pkg::RADIX_MAX;
    end else begin
      new_item.radix = radix_i;
    end
  end

  assign in_stall_o   = (cnt_q == uradix_pkg::QCNT_W'(uradix_pkg::QUEUE_DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_take_i && item_valid_o;
  assign item_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + uradix_pkg::QCNT_W'(push) - uradix_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ----- src/uradix_back.sv -----
// ----------------------------------------------------------------------------
// uradix_back
// Divides the value by the radix several quotient bits per cycle, stores
// each remainder as a digit and emits the digits most significant first.
// ----------------------------------------------------------------------------
module uradix_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  output logic                              item_take_o,
  input  uradix_pkg::item_t                 item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [uradix_pkg::CHAR_W-1:0]     digit_char_o,
  output logic                              final_digit_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_WR   = 2'd3;

  logic [1:0]                          state_q, state_d;
  logic [uradix_pkg::SHIFT_W-1:0]      shift_q, shift_d;
  logic [uradix_pkg::DIGIT_W-1:0]      rem_q, rem_d;
  logic [uradix_pkg::RADIX_W-1:0]      radix_q, radix_d;
  logic [uradix_pkg::STEP_W-1:0]       step_q, step_d;
  logic [uradix_pkg::COUNT_W-1:0]      count_q, count_d;
  logic [uradix_pkg::SLOT_W-1:0]       rd_idx_q, rd_idx_d;
  logic                                out_valid_q, out_valid_d;
  logic [uradix_pkg::CHAR_W-1:0]       char_q, char_d;
  logic                                final_q, final_d;

  logic [uradix_pkg::DIGIT_W-1:0]      digit_mem [uradix_pkg::DIGIT_SLOTS];
  logic [uradix_pkg::DIGIT_W-1:0]      rd_data_q;
  logic                                mem_we;

  logic [uradix_pkg::SHIFT_W-1:0]      quot;
  logic [uradix_pkg::DIGIT_W-1:0]      rem_next;
  logic                                last_step;
  logic                                out_load;

  always_comb begin
    logic [uradix_pkg::DIGIT_W:0]   t;
    logic [uradix_pkg::DIGIT_W-1:0] r;
    logic [uradix_pkg::SHIFT_W-1:0] s;
    r = rem_q;
    s = shift_q;
    for (int i = 0; i < uradix_pkg::BITS_PER_CYCLE; i++) begin
      t = {r, s[uradix_pkg::SHIFT_W-1]};
      if (t >= (uradix_pkg::DIGIT_W+1)'(radix_q)) begin
        t = t - (uradix_pkg::DIGIT_W+1)'(radix_q);
        s = {s[uradix_pkg::SHIFT_W-2:0], 1'b1};
      end else begin
        s = {s[uradix_pkg::SHIFT_W-2:0], 1'b0};
      end
      r = t[uradix_pkg::DIGIT_W-1:0];
    end
    quot     = s;
    rem_next = r;
  end

  assign last_step   = (step_q == uradix_pkg::STEP_W'(uradix_pkg::DIV_STEPS - 1));
  assign item_take_o = (state_q == ST_IDLE) && item_valid_i;
  assign out_load    = (state_q == ST_WR) && (!out_valid_q || !out_stall_i);
  assign mem_we      = (state_q == ST_DIV) && last_step;

  always_comb begin
    state_d     = state_q;
    shift_d     = shift_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    step_d      = step_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    char_d      = char_q;
    final_d     = final_q;
    out_valid_d = out_load || (out_valid_q && out_stall_i);
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          shift_d = item_i.value;
          radix_d = item_i.radix;
          rem_d   = '0;
          step_d  = '0;
          count_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        shift_d = quot;
        if (last_step) begin
          rem_d   = '0;
          step_d  = '0;
          count_d = count_q + 1'b1;
          if ((quot == '0) ||
              (count_q + 1'b1 == uradix_pkg::COUNT_W'(uradix_pkg::DIGIT_SLOTS))) begin
            rd_idx_d = count_q[uradix_pkg::SLOT_W-1:0];
            state_d  = ST_RD;
          end
        end else begin
          rem_d  = rem_next;
          step_d = step_q + 1'b1;
        end
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        if (out_load) begin
          char_d  = uradix_pkg::digit_to_ascii(rd_data_q);
          final_d = (rd_idx_q == '0);
          if (rd_idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - 1'b1;
            state_d  = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    char_q  <= char_d;
    final_q <= final_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[count_q[uradix_pkg::SLOT_W-1:0]] <= rem_next;
    end
    rd_data_q <= digit_mem[rd_idx_q];
  end

  assign out_valid_o   = out_valid_q;
  assign digit_char_o  = char_q;
  assign final_digit_o = final_q;

endmodule

// ----- src/unsigned_to_radix_ascii.sv -----
// ----------------------------------------------------------------------------
// unsigned_to_radix_ascii
// Converts an unsigned value to ASCII digits in radix 2 to 36, most
// significant digit first, with the last digit marked.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid_i/in_stall_o  number_i, radix_i
//   out       output     out_valid_o/out_stall_i digit_char_o, final_digit_o
//
// The engine takes one value at a time: it runs the eight-bit-per-cycle
// divider for each digit, then emits each digit through the registered
// digit memory read and the output register.
// A two-entry input queue accepts new values while the engine is busy.
// Reset is asynchronous and active low; it empties the queue and the output.
// A stalled output holds its digit and pauses the engine.
// ----------------------------------------------------------------------------
module unsigned_to_radix_ascii (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [uradix_pkg::NUMBER_W-1:0]   number_i,
  input  logic [uradix_pkg::RADIX_W-1:0]    radix_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [uradix_pkg::CHAR_W-1:0]     digit_char_o,
  output logic                              final_digit_o
);

  logic              item_valid;
  logic              item_take;
  uradix_pkg::item_t item;

  uradix_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .number_i     (number_i),
    .radix_i      (radix_i),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  uradix_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_take_o   (item_take),
    .item_i        (item),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digit_char_o  (digit_char_o),
    .final_digit_o (final_digit_o)
  );

endmodule

// ----- src/uradix_checker.sv -----
// ----------------------------------------------------------------------------
// uradix_checker
// Port-level checks of the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module uradix_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic [uradix_pkg::NUMBER_W-1:0]   number_i,
  input  logic [uradix_pkg::RADIX_W-1:0]    radix_i,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [uradix_pkg::CHAR_W-1:0]     digit_char_o,
  input  logic                              final_digit_o
);

  logic       in_acc;
  logic       out_done;
  logic [2:0] pending_q;
  logic       first_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_done = out_valid_o && !out_stall_i && final_digit_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      first_q   <= 1'b1;
    end else begin
      pending_q <= pending_q + 3'(in_acc) - 3'(out_done);
      if (out_valid_o && !out_stall_i) begin
        first_q <= final_digit_o;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digit_char_o) &&
    $stable(final_digit_o))
    else $error("Stalled output transaction changed.");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o >= 7'd48 && digit_char_o <= 7'd57) ||
    (digit_char_o >= 7'd65 && digit_char_o <= 7'd90))
    else $error("Output character is not a digit.");

  a_no_leading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_q && digit_char_o == 7'd48 |-> final_digit_o)
    else $error("Leading zero digit in a multi-digit result.");

  a_out_has_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("Output transaction without a pending input.");

  a_input_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q >= 3'd4 |-> in_stall_o)
    else $error("Input accepted beyond the queue and engine capacity.");

endmodule

bind unsigned_to_radix_ascii uradix_checker u_checker (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the unsigned to radix ASCII converter. Values and
// radices go in bursts with or without random gaps while the digit output runs
// free, stalls at random or on shifting patterns, or is once held off long
// enough to back up the input. The bench converts each value to its expected
// digit string and checks every digit transaction in order against it.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 700;
  localparam int HOLD_CYCLES    = 1500;
  localparam int REPORT_LIMIT   = 200;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_e;

  typedef struct packed {
    logic [uradix_pkg::CHAR_W-1:0] code;
    logic                          last;
  } digit_exp_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [uradix_pkg::NUMBER_W-1:0] number_i;
  logic [uradix_pkg::RADIX_W-1:0]  radix_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [uradix_pkg::CHAR_W-1:0]   digit_char_o;
  logic                            final_digit_o;

  digit_exp_t  pending_digits[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          sender_gaps = 1'b1;
  stall_mode_e stall_mode = STALL_RANDOM;
  int          hold_left = 0;
  int          pattern_phase = 0;
  int          pattern_period = 4;
  int          pattern_duty = 1;

  always #1 clk_i = ~clk_i;

  unsigned_to_radix_ascii u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .number_i     (number_i),
    .radix_i      (radix_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .final_digit_o(final_digit_o)
  );

  function automatic logic [uradix_pkg::RADIX_W-1:0] effective_radix(
      input logic [uradix_pkg::RADIX_W-1:0] radix);
    if (radix < uradix_pkg::RADIX_MIN) begin
      return uradix_pkg::RADIX_MIN;
    end
    if (radix > uradix_pkg::RADIX_MAX) begin
      return uradix_pkg::RADIX_MAX;
    end
    return radix;
  endfunction

  task automatic convert_to_digits(input logic [uradix_pkg::NUMBER_W-1:0] number,
                                   input logic [uradix_pkg::RADIX_W-1:0] radix);
    logic [uradix_pkg::NUMBER_W-1:0] rest;
    logic [uradix_pkg::NUMBER_W-1:0] base;
    logic [uradix_pkg::DIGIT_W-1:0]  digits[$];
    digit_exp_t                      entry;
    rest = '0;
    rest[uradix_pkg::VALUE_WIDTH-1:0] = number[uradix_pkg::VALUE_WIDTH-1:0];
    base = uradix_pkg::NUMBER_W'(effective_radix(radix));
    do begin
      digits.push_front(uradix_pkg::DIGIT_W'(rest % base));
      rest = rest / base;
    end while (rest != 0 && digits.size() < uradix_pkg::DIGIT_SLOTS);
    foreach (digits[k]) begin
      if (digits[k] < uradix_pkg::DECIMAL_LIMIT) begin
        entry.code = uradix_pkg::CHAR_ZERO + uradix_pkg::CHAR_W'(digits[k]);
      end else begin
        entry.code = uradix_pkg::CHAR_ALPHA +
                     uradix_pkg::CHAR_W'(digits[k] - uradix_pkg::DECIMAL_LIMIT);
      end
      entry.last = (k == digits.size() - 1);
      pending_digits.push_back(entry);
    end
  endtask

  task automatic send_number(input logic [uradix_pkg::NUMBER_W-1:0] number,
                             input logic [uradix_pkg::RADIX_W-1:0] radix);
    if (sender_gaps && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    in_valid_i <= 1'b1;
    number_i   <= number;
    radix_i    <= radix;
    do @(posedge clk_i); while (in_stall_o);
    convert_to_digits(number, radix);
    @(negedge clk_i);
  endtask

  function automatic logic [uradix_pkg::RADIX_W-1:0] random_radix();
    if ($urandom_range(0, 99) < 85) begin
      return uradix_pkg::RADIX_W'($urandom_range(uradix_pkg::RADIX_MIN,
                                                 uradix_pkg::RADIX_MAX));
    end
    return uradix_pkg::RADIX_W'($urandom_range(0, (1 << uradix_pkg::RADIX_W) - 1));
  endfunction

  function automatic logic [uradix_pkg::NUMBER_W-1:0] random_number(
      input logic [uradix_pkg::RADIX_W-1:0] radix);
    logic [uradix_pkg::NUMBER_W-1:0] base;
    logic [uradix_pkg::NUMBER_W-1:0] power;
    base = uradix_pkg::NUMBER_W'(effective_radix(radix));
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom} >> $urandom_range(0, uradix_pkg::NUMBER_W - 1);
      2: begin
        power = uradix_pkg::NUMBER_W'(1);
        repeat ($urandom_range(1, uradix_pkg::NUMBER_W)) begin
          if (power <= {uradix_pkg::NUMBER_W{1'b1}} / base) begin
            power = power * base;
          end
        end
        return power - uradix_pkg::NUMBER_W'($urandom_range(0, 1));
      end
      default: return uradix_pkg::NUMBER_W'($urandom_range(0, 32'(base * base)));
    endcase
  endfunction

  task automatic test_zero_value();
    send_number('0, uradix_pkg::RADIX_W'(2));
    send_number('0, uradix_pkg::RADIX_W'(10));
    send_number('0, uradix_pkg::RADIX_W'(36));
    send_number('0, uradix_pkg::RADIX_W'(0));
  endtask

  task automatic test_value_extremes();
    send_number('1, uradix_pkg::RADIX_W'(2));
    send_number('1, uradix_pkg::RADIX_W'(36));
    send_number('1, uradix_pkg::RADIX_W'(10));
    send_number(uradix_pkg::NUMBER_W'(1), uradix_pkg::RADIX_W'(2));
    send_number(uradix_pkg::NUMBER_W'(35), uradix_pkg::RADIX_W'(36));
    send_number(uradix_pkg::NUMBER_W'(36), uradix_pkg::RADIX_W'(36));
    send_number(uradix_pkg::NUMBER_W'(9), uradix_pkg::RADIX_W'(10));
    send_number(uradix_pkg::NUMBER_W'(10), uradix_pkg::RADIX_W'(16));
    send_number(uradix_pkg::NUMBER_W'(64'hDEAD_BEEF_0123_4567), uradix_pkg::RADIX_W'(16));
    send_number({1'b1, {(uradix_pkg::NUMBER_W - 1){1'b0}}}, uradix_pkg::RADIX_W'(3));
  endtask

  task automatic test_radix_clamp();
    send_number(uradix_pkg::NUMBER_W'(5), uradix_pkg::RADIX_W'(0));
    send_number(uradix_pkg::NUMBER_W'(5), uradix_pkg::RADIX_W'(1));
    send_number(uradix_pkg::NUMBER_W'(40), uradix_pkg::RADIX_W'(37));
    send_number(uradix_pkg::NUMBER_W'(1234567), uradix_pkg::RADIX_W'(63));
    send_number('1, uradix_pkg::RADIX_W'(1));
    send_number('1, uradix_pkg::RADIX_W'(63));
  endtask

  task automatic test_output_hold();
    logic [uradix_pkg::RADIX_W-1:0] radix;
    sender_gaps = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (10) begin
      radix = random_radix();
      send_number(random_number(radix), radix);
    end
    sender_gaps = 1'b1;
  endtask

  task automatic test_no_idling();
    logic [uradix_pkg::RADIX_W-1:0] radix;
    sender_gaps = 1'b0;
    stall_mode = STALL_NONE;
    repeat (40) begin
      radix = random_radix();
      send_number(random_number(radix), radix);
    end
  endtask

  task automatic test_random_values();
    logic [uradix_pkg::RADIX_W-1:0] radix;
    for (int i = 0; i < 430; i++) begin
      if (i % 50 == 0) begin
        stall_mode  = stall_mode_e'($urandom_range(0, 2));
        sender_gaps = $urandom_range(0, 3) != 0;
      end
      radix = random_radix();
      send_number(random_number(radix), radix);
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        case (stall_mode)
          STALL_NONE: out_stall_i <= 1'b0;
          STALL_RANDOM: out_stall_i <= $urandom_range(0, 99) < 35;
          default: begin
            out_stall_i <= pattern_phase < pattern_duty;
            pattern_phase++;
            if (pattern_phase >= pattern_period) begin
              pattern_phase  = 0;
              pattern_period = $urandom_range(2, 16);
              pattern_duty   = $urandom_range(0, pattern_period - 1);
            end
          end
        endcase
      end
    end
  end

  task automatic report_mismatch(input string field, input int want, input int got);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_digits
    digit_exp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digits.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("%0t: unexpected digit transaction, expected none, actual %0h final %0b",
                   $time, digit_char_o, final_digit_o);
        end
      end else begin
        want = pending_digits.pop_front();
        if (digit_char_o !== want.code) begin
          report_mismatch("digit_char", int'(want.code), int'(digit_char_o));
        end
        if (final_digit_o !== want.last) begin
          report_mismatch("final_digit", int'(want.last), int'(final_digit_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (idle_cycles < WATCHDOG_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    number_i   = '0;
    radix_i    = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_zero_value();
    test_value_extremes();
    test_radix_clamp();
    test_output_hold();
    test_no_idling();
    test_random_values();
    in_valid_i <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
